[design/tob_pkg.sv]
// shared types, constants and helpers for the track overcurrent breaker
// no dependencies; imported by tob_ctrl, tob_dp and the top level
package tob_pkg;

	localparam int ADC_BITS = 10;
	localparam int LEVEL_W  = ADC_BITS + 8;
	localparam int AGE_W    = 16;
	localparam int CFG_W    = 16;
	localparam int ALPHA_W  = 9;
	localparam int MA_W     = 16;
	localparam int IDX_W    = 3;
	localparam int ACT_W    = 3;

	localparam logic [AGE_W-1:0]   AGE_MAX    = '1;
	localparam logic [ALPHA_W-1:0] ALPHA_FULL = ALPHA_W'(256);
	localparam logic [MA_W-1:0]    MA_MAX     = '1;

	localparam logic [CFG_W-1:0]   RST_TRIP_THR   = CFG_W'(2000);
	localparam logic [CFG_W-1:0]   RST_PROG_THR   = CFG_W'(250);
	localparam logic [CFG_W-1:0]   RST_PROG_WIN   = CFG_W'(100);
	localparam logic [CFG_W-1:0]   RST_MA_PER_CNT = CFG_W'(1024);
	localparam logic [ALPHA_W-1:0] RST_ALPHA      = ALPHA_W'(128);
	localparam logic [CFG_W-1:0]   RST_SAMPLE_INT = CFG_W'(1);
	localparam logic [CFG_W-1:0]   RST_RETRY      = CFG_W'(10000);

	typedef enum logic [ACT_W-1:0] {
		ACT_TICK      = 3'd0,
		ACT_POWER     = 3'd1,
		ACT_PROG_MODE = 3'd2,
		ACT_DIRECTION = 3'd3,
		ACT_CUTOUT    = 3'd4
	} action_t;

	typedef enum logic [IDX_W-1:0] {
		REG_TRIP_THR   = 3'd0,
		REG_PROG_THR   = 3'd1,
		REG_PROG_WIN   = 3'd2,
		REG_MA_PER_CNT = 3'd3,
		REG_ALPHA      = 3'd4,
		REG_SAMPLE_INT = 3'd5,
		REG_RETRY      = 3'd6
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_MUL,
		ST_ACC,
		ST_SCALE,
		ST_FINISH
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic capture;
		logic exec;
		logic mul;
		logic acc;
		logic scale;
		logic finish;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic eval_now;
		logic out_full;
	} sts_t;

	function automatic logic [AGE_W-1:0] age_up(input logic [AGE_W-1:0] a);
		age_up = (a == AGE_MAX) ? AGE_MAX : a + AGE_W'(1);
	endfunction

endpackage

[design/tob_ctrl.sv]
// controller state machine for the track overcurrent breaker
// depends on tob_pkg; drives tob_dp through cmd_t and reads sts_t
module tob_ctrl import tob_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_n = ST_EXEC;
			ST_EXEC:   state_n = sts.eval_now ? ST_MUL : ST_SCALE;
			ST_MUL:    state_n = ST_ACC;
			ST_ACC:    state_n = ST_SCALE;
			ST_SCALE:  state_n = ST_FINISH;
			ST_FINISH: if (!sts.out_full || out_ready) state_n = ST_IDLE;
			default:   state_n = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_EXEC:   cmd.exec   = 1'b1;
			ST_MUL:    cmd.mul    = 1'b1;
			ST_ACC:    cmd.acc    = 1'b1;
			ST_SCALE:  cmd.scale  = 1'b1;
			ST_FINISH: cmd.finish = !sts.out_full || out_ready;
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

[design/tob_dp.sv]
// datapath: configuration registers, track state, smoothing, scaling and trip logic
// depends on tob_pkg; sequenced by tob_ctrl
module tob_dp import tob_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	output sts_t                sts,
	input  logic                cfg_we,
	input  logic [IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]    cfg_data,
	input  logic [ACT_W-1:0]    action,
	input  logic [ADC_BITS-1:0] adc_sample,
	input  logic                flag,
	input  logic                announce,
	input  logic                out_ready,
	output logic                out_valid,
	output logic                enable_out,
	output logic                drive_a_out,
	output logic                drive_b_out,
	output logic                limit_out,
	output logic                cutout_n_out,
	output logic                power_event,
	output logic                trip_flag,
	output logic [MA_W-1:0]     current_ma,
	output logic                limiting_out
);

	localparam int RAWA_W = ADC_BITS + ALPHA_W;
	localparam int LVP_W  = LEVEL_W + ALPHA_W;
	localparam int SUM_W  = LEVEL_W + 1;
	localparam int PROD_W = LEVEL_W + CFG_W;

	// configuration
	logic [CFG_W-1:0]   trip_thr_q, prog_thr_q, prog_win_q, ma_per_cnt_q;
	logic [CFG_W-1:0]   sample_int_q, retry_q;
	logic [ALPHA_W-1:0] alpha_q;

	// captured item
	action_t             action_q;
	logic [ADC_BITS-1:0] adc_q;
	logic                flag_q, announce_q;

	// track state
	logic [LEVEL_W-1:0] level_q;
	logic [AGE_W-1:0]   sample_age_q, trip_age_q, ppa_q;
	logic power_on_q, tripped_q, prog_mode_q, cutout_q, drive_a_q, drive_b_q;
	logic eval_q, event_q;

	// arithmetic
	logic [RAWA_W-1:0] rawa_q;
	logic [LVP_W-1:0]  lvp_q;
	logic [MA_W-1:0]   ma_q;

	logic [ALPHA_W-1:0] a_eff;
	logic [ALPHA_W-1:0] a_inv;
	logic [AGE_W-1:0]   sample_age_up;
	logic [SUM_W-1:0]   level_sum;
	logic [PROD_W-1:0]  scale_prod;
	logic [LEVEL_W-1:0] scale_hi;
	logic               lim_now, lim_after, trip_go, retry_go, pwr_change;
	logic [CFG_W-1:0]   thr;
	logic               power_n;
	logic [AGE_W-1:0]   ppa_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trip_thr_q   <= RST_TRIP_THR;
			prog_thr_q   <= RST_PROG_THR;
			prog_win_q   <= RST_PROG_WIN;
			ma_per_cnt_q <= RST_MA_PER_CNT;
			alpha_q      <= RST_ALPHA;
			sample_int_q <= RST_SAMPLE_INT;
			retry_q      <= RST_RETRY;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				REG_TRIP_THR:   trip_thr_q   <= cfg_data;
				REG_PROG_THR:   prog_thr_q   <= cfg_data;
				REG_PROG_WIN:   prog_win_q   <= cfg_data;
				REG_MA_PER_CNT: ma_per_cnt_q <= cfg_data;
				REG_ALPHA:      alpha_q      <= cfg_data[ALPHA_W-1:0];
				REG_SAMPLE_INT: sample_int_q <= cfg_data;
				REG_RETRY:      retry_q      <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q   <= action_t'(action);
			adc_q      <= adc_sample;
			flag_q     <= flag;
			announce_q <= announce;
		end
	end

	// alpha above full weight acts as full weight
	assign a_eff         = (alpha_q > ALPHA_FULL) ? ALPHA_FULL : alpha_q;
	assign a_inv         = ALPHA_FULL - a_eff;
	assign sample_age_up = age_up(sample_age_q);

	assign sts.eval_now = (action_q == ACT_TICK) && (sample_age_up > sample_int_q);

	// level = raw*alpha + round((level*(256-alpha)) / 256)
	assign level_sum = SUM_W'(rawa_q) + SUM_W'((lvp_q + LVP_W'(128)) >> 8);

	assign scale_prod = PROD_W'(level_q) * PROD_W'(ma_per_cnt_q);
	assign scale_hi   = scale_prod[PROD_W-1:CFG_W];

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			rawa_q <= RAWA_W'(adc_q) * RAWA_W'(a_eff);
			lvp_q  <= LVP_W'(level_q) * LVP_W'(a_inv);
		end
		if (cmd.scale) begin
			ma_q <= (scale_hi > LEVEL_W'(MA_MAX)) ? MA_MAX : scale_hi[MA_W-1:0];
		end
	end

	// trip decision
	assign lim_now    = prog_mode_q && ((prog_win_q == '0) || (ppa_q < prog_win_q));
	assign thr        = lim_now ? prog_thr_q : trip_thr_q;
	assign trip_go    = eval_q && (ma_q > thr) && power_on_q;
	assign retry_go   = eval_q && !trip_go && (ma_q < thr) && tripped_q
		&& (trip_age_q > retry_q);
	assign pwr_change = trip_go || retry_go;
	assign power_n    = trip_go ? 1'b0 : (retry_go ? 1'b1 : power_on_q);
	assign ppa_n      = (pwr_change && prog_mode_q) ? '0 : ppa_q;
	assign lim_after  = prog_mode_q && ((prog_win_q == '0) || (ppa_n < prog_win_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q      <= '0;
			sample_age_q <= '0;
			trip_age_q   <= '0;
			ppa_q        <= '0;
			power_on_q   <= 1'b0;
			tripped_q    <= 1'b0;
			prog_mode_q  <= 1'b1;
			cutout_q     <= 1'b0;
			drive_a_q    <= 1'b0;
			drive_b_q    <= 1'b0;
			eval_q       <= 1'b0;
			event_q      <= 1'b0;
		end else begin
			if (cmd.exec) begin
				eval_q  <= 1'b0;
				event_q <= 1'b0;
				unique case (action_q)
					ACT_TICK: begin
						trip_age_q <= age_up(trip_age_q);
						ppa_q      <= age_up(ppa_q);
						if (sts.eval_now) begin
							sample_age_q <= '0;
							eval_q       <= 1'b1;
						end else begin
							sample_age_q <= sample_age_up;
						end
					end
					ACT_POWER: begin
						power_on_q <= flag_q;
						if (prog_mode_q) ppa_q <= '0;
						event_q <= announce_q;
					end
					ACT_PROG_MODE: prog_mode_q <= flag_q;
					ACT_DIRECTION: begin
						if (!cutout_q) begin
							drive_a_q <= flag_q;
							drive_b_q <= !flag_q;
						end
					end
					ACT_CUTOUT: begin
						cutout_q <= flag_q;
						if (flag_q) begin
							drive_a_q <= 1'b0;
							drive_b_q <= 1'b0;
						end
					end
					default: begin
					end
				endcase
			end
			if (cmd.acc) begin
				level_q <= level_sum[LEVEL_W-1:0];
			end
			if (cmd.finish) begin
				power_on_q <= power_n;
				ppa_q      <= ppa_n;
				if (trip_go) begin
					tripped_q  <= 1'b1;
					trip_age_q <= '0;
				end else if (retry_go) begin
					tripped_q <= 1'b0;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.finish) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			enable_out   <= power_n;
			drive_a_out  <= drive_a_q;
			drive_b_out  <= drive_b_q;
			limit_out    <= prog_mode_q;
			cutout_n_out <= !cutout_q;
			power_event  <= event_q || pwr_change;
			trip_flag    <= trip_go ? 1'b1 : (retry_go ? 1'b0 : tripped_q);
			current_ma   <= ma_q;
			limiting_out <= lim_after;
		end
	end

	assign sts.out_full = out_valid;

endmodule

[design/track_overcurrent_breaker_core.sv]
// top level of the track overcurrent breaker
// depends on tob_pkg, tob_ctrl and tob_dp
//
// usage:
//   input channel (in_valid/in_ready) carries one action per transaction:
//   tick with converter sample, power command, programming mode, direction
//   or cutout. every transaction yields exactly one result transaction on
//   the output channel (out_valid/out_ready) with the drive levels, trip
//   status, smoothed current in milliamps and the limiting indication.
//   configuration: cfg_we writes cfg_data into register cfg_index at the
//   clock edge, no wait; write only while the block is idle.
//   sequence: a tick that runs an evaluation goes from accept to out_valid
//   through age update, two smoothing multiplies, accumulate, current
//   scaling and trip decision; every other item skips the smoothing steps.
//   one item in flight at a time: the next is accepted only once the
//   shared controller sequence has returned to idle.
//   reset: arst_n clears state, loads register defaults, programming mode on.
//   a stalled receiver holds the result in the output register; the next
//   transaction is still accepted and worked up to the decision step, where
//   it waits until the held result is taken.
module track_overcurrent_breaker_core import tob_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	// configuration write port
	input  logic                cfg_we,
	input  logic [IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]    cfg_data,
	// input channel
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [ACT_W-1:0]    action,
	input  logic [ADC_BITS-1:0] adc_sample,
	input  logic                flag,
	input  logic                announce,
	// output channel
	output logic                out_valid,
	input  logic                out_ready,
	output logic                enable_out,
	output logic                drive_a_out,
	output logic                drive_b_out,
	output logic                limit_out,
	output logic                cutout_n_out,
	output logic                power_event,
	output logic                trip_flag,
	output logic [MA_W-1:0]     current_ma,
	output logic                limiting_out
);

	cmd_t cmd;
	sts_t sts;

	// sequencer
	tob_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// state, arithmetic and output register
	tob_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.action       (action),
		.adc_sample   (adc_sample),
		.flag         (flag),
		.announce     (announce),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.enable_out   (enable_out),
		.drive_a_out  (drive_a_out),
		.drive_b_out  (drive_b_out),
		.limit_out    (limit_out),
		.cutout_n_out (cutout_n_out),
		.power_event  (power_event),
		.trip_flag    (trip_flag),
		.current_ma   (current_ma),
		.limiting_out (limiting_out)
	);

	// one item at a time: accepting a transaction closes the input
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted while an item is in progress");

	// cutout forces both bridge signals low
	a_cutout_drive: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !cutout_n_out) |-> (!drive_a_out && !drive_b_out))
		else $error("bridge driven during cutout");

	// limiting only in programming mode
	a_limit_prog: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && limiting_out) |-> limit_out)
		else $error("limiting reported outside programming mode");

	// a finished result never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.finish && out_valid) |-> out_ready)
		else $error("held result overwritten");

endmodule
